/* src/brqt_pkg.sv */
// Package for the 1-bit bitmap quarter-turn rotator.
// Beat types, register/opcode/mode codes and frame store geometry; no dependencies.
package brqt_pkg;

  localparam int MaxRows = 64;
  localparam int MaxCols = 64;
  localparam int RowW    = $clog2(MaxRows);
  localparam int ColW    = $clog2(MaxCols);
  localparam int AddrW   = RowW + ColW;
  localparam int Depth   = 1 << AddrW;
  localparam int DimW    = 7;
  localparam int CfgIdxW = 2;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EMIT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    MODE_LEFT  = 2'd0,
    MODE_RIGHT = 2'd1,
    MODE_PASS  = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROWS = 2'd0,
    REG_COLS = 2'd1,
    REG_MODE = 2'd2
  } reg_e;

  typedef struct packed {
    logic opcode;
    logic pixel_in;
  } in_t;

  typedef struct packed {
    logic pixel_out;
    logic frame_last;
  } out_t;

  // frame store access from the controller
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic             wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  // dimension register -> effective size minus one (0 counts as 1, saturates at max)
  function automatic logic [RowW-1:0] row_m1(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) r = DimW'(1);
    else if (v > DimW'(MaxRows)) r = DimW'(MaxRows);
    return RowW'(r - DimW'(1));
  endfunction

  function automatic logic [ColW-1:0] col_m1(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) r = DimW'(1);
    else if (v > DimW'(MaxCols)) r = DimW'(MaxCols);
    return ColW'(r - DimW'(1));
  endfunction

endpackage

/* src/brqt_store.sv */
// Frame store: one bit per pixel, one write and one read port, registered read data.
// Depends on brqt_pkg.
module brqt_store (
  input  logic              clk_i,
  input  brqt_pkg::mem_req_t req_i,
  output logic              rd_o
);
  import brqt_pkg::*;

  logic mem [Depth];
  logic rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem[req_i.raddr];
    end
  end

  assign rd_o = rd_q;

endmodule

/* src/brqt_ctrl.sv */
// Controller: config registers, load/emit counters, rotated address and output valid.
// Depends on brqt_pkg.
module brqt_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  brqt_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        out_last_o,
  input  logic                        cfg_valid_i,
  input  logic [brqt_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [brqt_pkg::DimW-1:0]   cfg_data_i,
  output brqt_pkg::mem_req_t          mem_req_o,
  output logic                        frame_ready_o
);
  import brqt_pkg::*;

  logic [DimW-1:0] rows_q, rows_d, cols_q, cols_d;
  logic [1:0]      mode_q, mode_d;
  logic [RowW-1:0] ld_row_q, ld_row_d;
  logic [ColW-1:0] ld_col_q, ld_col_d;
  logic [ColW-1:0] em_row_q, em_row_d;   // output rows span up to MaxCols
  logic [RowW-1:0] em_col_q, em_col_d;
  logic            ready_q, ready_d;
  logic            oval_q, oval_d;
  logic            olast_q, olast_d;

  logic [RowW-1:0] r_m1;
  logic [ColW-1:0] c_m1;
  logic [RowW-1:0] sr;
  logic [ColW-1:0] sc;
  logic [ColW-1:0] orow_m1;   // compared against emit row/col (both 6 bits here)
  logic [RowW-1:0] ocol_m1;
  logic            in_fire, rotated, em_last, ld_last, ld_first;

  // a config write owns the cycle, so the input beat waits
  assign in_ready_o = (!oval_q || out_ready_i) && !cfg_valid_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign r_m1       = row_m1(rows_q);
  assign c_m1       = col_m1(cols_q);
  assign rotated    = (mode_q == MODE_LEFT) || (mode_q == MODE_RIGHT);

  always_comb begin
    case (mode_q)
      MODE_LEFT: begin
        sr = RowW'(em_col_q);
        sc = c_m1 - ColW'(em_row_q);
      end
      MODE_RIGHT: begin
        sr = r_m1 - RowW'(em_col_q);
        sc = ColW'(em_row_q);
      end
      default: begin
        sr = RowW'(em_row_q);
        sc = ColW'(em_col_q);
      end
    endcase
    orow_m1 = rotated ? c_m1 : ColW'(r_m1);
    ocol_m1 = rotated ? RowW'(r_m1) : RowW'(c_m1);
  end

  assign em_last  = (em_row_q == orow_m1) && (em_col_q == ocol_m1);
  assign ld_first = (ld_row_q == '0) && (ld_col_q == '0);
  assign ld_last  = (ld_row_q == r_m1) && (ld_col_q == c_m1);

  always_comb begin
    rows_d   = rows_q;
    cols_d   = cols_q;
    mode_d   = mode_q;
    ld_row_d = ld_row_q;
    ld_col_d = ld_col_q;
    em_row_d = em_row_q;
    em_col_d = em_col_q;
    ready_d  = ready_q;
    oval_d   = oval_q && !out_ready_i;
    olast_d  = olast_q;
    mem_req_o = '0;
    mem_req_o.waddr = {ld_row_q, ld_col_q};
    mem_req_o.wdata = in_data_i.pixel_in;
    mem_req_o.raddr = {sr, sc};

    if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_ROWS, REG_COLS: begin
          if (reg_e'(cfg_index_i) == REG_ROWS) rows_d = cfg_data_i;
          else                                 cols_d = cfg_data_i;
          ld_row_d = '0;
          ld_col_d = '0;
          ready_d  = 1'b0;
          em_row_d = '0;
          em_col_d = '0;
        end
        REG_MODE: begin
          mode_d   = cfg_data_i[1:0];
          em_row_d = '0;
          em_col_d = '0;
        end
        default: ;
      endcase
    end else if (in_fire) begin
      if (op_e'(in_data_i.opcode) == OP_LOAD) begin
        mem_req_o.we = 1'b1;
        if (ld_first) begin
          ready_d  = 1'b0;
          em_row_d = '0;
          em_col_d = '0;
        end
        if (ld_last) begin
          ld_row_d = '0;
          ld_col_d = '0;
          ready_d  = 1'b1;
        end else if (ld_col_q == c_m1) begin
          ld_col_d = '0;
          ld_row_d = ld_row_q + RowW'(1);
        end else begin
          ld_col_d = ld_col_q + ColW'(1);
        end
      end else if (ready_q) begin
        mem_req_o.re = 1'b1;
        oval_d  = 1'b1;
        olast_d = em_last;
        if (em_last) begin
          em_row_d = '0;
          em_col_d = '0;
        end else if (em_col_q == ocol_m1) begin
          em_col_d = '0;
          em_row_d = em_row_q + ColW'(1);
        end else begin
          em_col_d = em_col_q + RowW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q   <= DimW'(1);
      cols_q   <= DimW'(1);
      mode_q   <= MODE_LEFT;
      ld_row_q <= '0;
      ld_col_q <= '0;
      em_row_q <= '0;
      em_col_q <= '0;
      ready_q  <= 1'b0;
      oval_q   <= 1'b0;
    end else begin
      rows_q   <= rows_d;
      cols_q   <= cols_d;
      mode_q   <= mode_d;
      ld_row_q <= ld_row_d;
      ld_col_q <= ld_col_d;
      em_row_q <= em_row_d;
      em_col_q <= em_col_d;
      ready_q  <= ready_d;
      oval_q   <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    olast_q <= olast_d;
  end

  assign out_valid_o   = oval_q;
  assign out_last_o    = olast_q;
  assign frame_ready_o = ready_q;

endmodule

/* src/bitmap_rotate_quarter_turn.sv */
// Top level of the 1-bit bitmap quarter-turn rotator.
// Depends on brqt_pkg, brqt_ctrl and brqt_store.
//
// Load beats (opcode 0) write pixels of an R x C image, row-major, into a
// 4096 x 1 frame store laid out at row*64+col, so no address multiply is needed.
// Emit beats (opcode 1) read the image back rotated left, rotated right, or
// unchanged (mode 2 or 3), row-major, one pixel per beat, with frame_last on
// the final pixel; readout then wraps and can be repeated. Emits before a frame
// is fully loaded are consumed and give no result. The input beat is accepted
// and the store is written or read at the same edge; the emitted pixel comes
// out of the store's registered read port, which is the output register, in
// the following cycle. One beat per cycle is sustained as long as
// the output side keeps taking results; in_ready_o drops while a result
// waits and in any cycle that carries a config write. The store is not
// cleared at reset; its contents are valid only once written. Config writes
// are taken at any cycle (cfg_ready_o is always high) and belong in idle
// periods. Writing row_count or column_count discards the loaded frame;
// writing turn_mode restarts the readout only.
module bitmap_rotate_quarter_turn (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  brqt_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output brqt_pkg::out_t               out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [brqt_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [brqt_pkg::DimW-1:0]    cfg_data_i
);
  import brqt_pkg::*;

  mem_req_t mem_req;
  logic     rd_pixel;
  logic     last_flag;
  logic     frame_ready;

  assign cfg_ready_o = 1'b1;

  brqt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_last_o    (last_flag),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .mem_req_o     (mem_req),
    .frame_ready_o (frame_ready)
  );

  brqt_store u_store (
    .clk_i (clk_i),
    .req_i (mem_req),
    .rd_o  (rd_pixel)
  );

  assign out_data_o.pixel_out  = rd_pixel;
  assign out_data_o.frame_last = last_flag;

  // a load beat never produces a result
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !cfg_valid_i && in_data_i.opcode == OP_LOAD)
      |=> !out_valid_o)
    else $error("result after load beat");

  // an emit before the frame is complete is dropped
  a_emit_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !cfg_valid_i && in_data_i.opcode == OP_EMIT
      && !frame_ready) |=> !out_valid_o)
    else $error("result for emit before frame ready");

  // a dimension write discards the loaded frame
  a_dim_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && (cfg_index_i == REG_ROWS || cfg_index_i == REG_COLS))
      |=> !frame_ready)
    else $error("frame still ready after dimension write");

  // write and read of the store never happen in the same cycle
  a_store_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req.we && mem_req.re))
    else $error("store write and read together");

endmodule

/* bench/bitmap_rotate_quarter_turn_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for bitmap_rotate_quarter_turn: directed table, then random frames.
// Depends on brqt_pkg and the RTL top; results checked against an in-bench frame predictor.
module bitmap_rotate_quarter_turn_tb;
  import brqt_pkg::*;

  // ---------------------------------------------------------------------------
  // Run constants
  // ---------------------------------------------------------------------------
  localparam int RandBeats   = 1450;     // random input beats after the table
  localparam int TailCycles  = 8;        // registered store read, with margin
  localparam int LongHold    = 48;       // receiver hold-off to back the block up
  localparam int LimitCycles = 200_000;  // watchdog

  // out-of-range register index, must be ignored by the block
  localparam logic [CfgIdxW-1:0] RegNone  = 2'd3;
  // mode three: unknown direction, behaves as pass-through
  localparam logic [1:0]         ModeOdd  = 2'd3;

  // how a sent beat's result is judged
  typedef enum logic [1:0] {
    EXP_MODEL,  // whatever the frame predictor says
    EXP_NONE,   // typed in: no result at all
    EXP_TYPED   // typed in: exactly the result given in the table
  } exp_e;

  typedef enum logic {
    ROW_REG,
    ROW_BEAT
  } row_e;

  // one line of the directed table
  typedef struct {
    row_e                kind;
    logic [CfgIdxW-1:0]  idx;
    logic [DimW-1:0]     val;
    in_t                 beat;
    exp_e                chk;
    out_t                want;
  } step_t;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic               clk;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  in_t                in_data     = '0;
  logic               out_ready   = 1'b0;
  logic               cfg_valid   = 1'b0;
  logic [CfgIdxW-1:0] cfg_index   = '0;
  logic [DimW-1:0]    cfg_data    = '0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic               cfg_ready_o;
  out_t               out_data_o;

  // tag travelling with the beat on the input channel (bench side only)
  exp_e               tag_kind    = EXP_MODEL;
  out_t               tag_want    = '0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  bitmap_rotate_quarter_turn DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Frame predictor: own copy of registers, store and counters
  // ---------------------------------------------------------------------------
  logic [DimW-1:0] rows_raw;
  logic [DimW-1:0] cols_raw;
  logic [1:0]      turn;
  bit              pixels [0:Depth-1];
  int              load_pos;
  int              emit_r;
  int              emit_c;
  bit              frame_ok;

  out_t            pixel_q [$];   // pixels the block still owes us, oldest first
  int              mismatches   = 0;
  int              results_seen = 0;
  int              cycles       = 0;
  bit              calm         = 1'b0;  // set near the end: no more idling

  // 0 counts as 1, anything above the cap saturates
  function automatic int dim_of(input logic [DimW-1:0] v, input int cap);
    if (v == '0) return 1;
    if (int'(v) > cap) return cap;
    return int'(v);
  endfunction

  // dimension write discards the loaded frame
  function automatic void drop_frame();
    load_pos = 0;
    frame_ok = 1'b0;
    emit_r   = 0;
    emit_c   = 0;
  endfunction

  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx,
                                    input logic [DimW-1:0] val);
    case (idx)
      REG_ROWS: begin
        rows_raw = val;
        drop_frame();
      end
      REG_COLS: begin
        cols_raw = val;
        drop_frame();
      end
      REG_MODE: begin
        // readout restarts, frame stays
        turn   = val[1:0];
        emit_r = 0;
        emit_c = 0;
      end
      default: ;  // unknown index: ignored
    endcase
  endfunction

  // Advance the predictor by one accepted beat; returns 1 when a pixel comes out.
  function automatic bit step_frame(input in_t b, output out_t r);
    int  nr, nc, orows, ocols, sr, sc;
    bit  last;
    nr = dim_of(rows_raw, MaxRows);
    nc = dim_of(cols_raw, MaxCols);
    r  = '0;
    if (b.opcode == OP_LOAD) begin
      if (load_pos >= nr * nc) load_pos = 0;
      // first pixel of a new frame: old frame is gone, readout restarts
      if (load_pos == 0) begin
        frame_ok = 1'b0;
        emit_r   = 0;
        emit_c   = 0;
      end
      pixels[load_pos] = b.pixel_in;
      load_pos++;
      if (load_pos >= nr * nc) begin
        load_pos = 0;
        frame_ok = 1'b1;
      end
      return 1'b0;
    end
    // emit before the frame is complete: swallowed
    if (!frame_ok) return 1'b0;
    if (turn == MODE_LEFT || turn == MODE_RIGHT) begin
      orows = nc;
      ocols = nr;
    end else begin
      orows = nr;
      ocols = nc;
    end
    if (emit_r >= orows || emit_c >= ocols) begin
      emit_r = 0;
      emit_c = 0;
    end
    if (turn == MODE_LEFT) begin
      sr = emit_c;
      sc = nc - 1 - emit_r;
    end else if (turn == MODE_RIGHT) begin
      sr = nr - 1 - emit_c;
      sc = emit_r;
    end else begin
      // pass-through, mode two or three
      sr = emit_r;
      sc = emit_c;
    end
    last         = (emit_r == orows - 1) && (emit_c == ocols - 1);
    r.pixel_out  = pixels[sr * nc + sc];
    r.frame_last = last;
    if (last) begin
      // wrap so the same frame can be read again
      emit_r = 0;
      emit_c = 0;
    end else if (emit_c + 1 >= ocols) begin
      emit_c = 0;
      emit_r++;
    end else begin
      emit_c++;
    end
    return 1'b1;
  endfunction

  initial begin
    rows_raw = 7'd1;
    cols_raw = 7'd1;
    turn     = MODE_LEFT;
    drop_frame();
  end

  // ---------------------------------------------------------------------------
  // Monitor: config writes and input beats feed the predictor, output beats
  // are checked against the oldest owed pixel. Everything is sampled at the
  // rising edge, before the NBA updates of that edge land.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    out_t pred;
    out_t owed;
    bit   made;
    if (rst_n) begin
      if (cfg_valid && cfg_ready_o) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready_o) begin
        made = step_frame(in_data, pred);
        if (tag_kind == EXP_TYPED) pixel_q.push_back(tag_want);
        else if (tag_kind == EXP_MODEL && made) pixel_q.push_back(pred);
      end
      if (out_valid_o && out_ready) begin
        results_seen++;
        if (pixel_q.size() == 0) begin
          if (mismatches < 10)
            $display("[%0d] unexpected result beat: pixel %0b last %0b", cycles,
                     out_data_o.pixel_out, out_data_o.frame_last);
          mismatches++;
        end else begin
          owed = pixel_q.pop_front();
          if (out_data_o.pixel_out !== owed.pixel_out ||
              out_data_o.frame_last !== owed.frame_last) begin
            if (mismatches < 10)
              $display("[%0d] result %0d: expected pixel %0b last %0b, got pixel %0b last %0b",
                       cycles, results_seen, owed.pixel_out, owed.frame_last,
                       out_data_o.pixel_out, out_data_o.frame_last);
            mismatches++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LimitCycles) begin
      $display("bitmap_rotate_quarter_turn_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random ready bursts, plus a long hold every few hundred results
  // while the sender keeps pushing, so the output reg fills and in_ready drops.
  // ---------------------------------------------------------------------------
  initial begin : taker
    int hold_mark;
    hold_mark = 30;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!calm && results_seen >= hold_mark) begin
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        hold_mark += 500;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one beat and hold it until taken. An optional idle burst comes first.
  // Valid stays high on return, so back-to-back beats need no re-raise.
  task automatic push_beat(input in_t b, input exp_e k, input out_t w);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    tag_kind <= k;
    tag_want <= w;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
  endtask

  // Stop offering, wait for every owed pixel, then give the pipe time to empty.
  // Needed before any config write: a swallowed emit may still be in flight.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DimW-1:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    step_t           script [31];
    in_t             plan [$];
    in_t             b;
    int              phase, pick, nr, nc, reps, fed;
    logic [DimW-1:0] rv, cv;

    // Directed table. Typed expectations only where obvious: 1x1 frames and
    // "no result" cases; the 1x3 rotations go through the predictor.
    script = '{
      // after reset the 1x1 frame is not loaded: emit is swallowed
      '{ROW_BEAT, REG_ROWS, 7'd0,  '{OP_EMIT, 1'b1}, EXP_NONE,  '{1'b0, 1'b0}},
      '{ROW_BEAT, REG_ROWS, 7'd0,  '{OP_LOAD, 1'b1}, EXP_NONE,  '{1'b0, 1'b0}},
      // 1x1 frame: every pixel is the last one, readout wraps
      '{ROW_BEAT, REG_ROWS, 7'd0,  '{OP_EMIT, 1'b0}, EXP_TYPED, '{1'b1, 1'b1}},
      '{ROW_BEAT, REG_ROWS, 7'd0,  '{OP_EMIT, 1'b1}, EXP_TYPED, '{1'b1, 1'b1}},
      // reload of the first pixel replaces the frame
      '{ROW_BEAT, REG_ROWS, 7'd0,  '{OP_LOAD, 1'b0}, EXP_NONE,  '{1'b0, 1'b0}},
      '{ROW_BEAT, REG_ROWS, 7'd0,  '{OP_EMIT, 1'b0}, EXP_TYPED, '{1'b0, 1'b1}},
      // mode write keeps the frame
      '{ROW_REG,  REG_MODE, DimW'(MODE_PASS), '{OP_LOAD, 1'b0}, EXP_NONE, '{1'b0, 1'b0}},
      '{ROW_BEAT, REG_ROWS, 7'd0,  '{OP_EMIT, 1'b1}, EXP_TYPED, '{1'b0, 1'b1}},
      // unknown register index with all data bits set: no effect
      '{ROW_REG,  RegNone,  7'h7F, '{OP_LOAD, 1'b0}, EXP_NONE,  '{1'b0, 1'b0}},
      '{ROW_BEAT, REG_ROWS, 7'd0,  '{OP_EMIT, 1'b0}, EXP_TYPED, '{1'b0, 1'b1}},
      // zero rows counts as one; dimension write discards the frame
      '{ROW_REG,  REG_ROWS, 7'd0,  '{OP_LOAD, 1'b0}, EXP_NONE,  '{1'b0, 1'b0}},
      '{ROW_REG,  REG_COLS, 7'd3,  '{OP_LOAD, 1'b0}, EXP_NONE,  '{1'b0, 1'b0}},
      '{ROW_REG,  REG_MODE, DimW'(MODE_LEFT), '{OP_LOAD, 1'b0}, EXP_NONE, '{1'b0, 1'b0}},
      '{ROW_BEAT, REG_ROWS, 7'd0,  '{OP_EMIT, 1'b1}, EXP_NONE,  '{1'b0, 1'b0}},
      // 1x3 frame 1 0 1, read out left, mode three, right
      '{ROW_BEAT, REG_ROWS, 7'd0,  '{OP_LOAD, 1'b1}, EXP_MODEL, '{1'b0, 1'b0}},
      '{ROW_BEAT, REG_ROWS, 7'd0,  '{OP_LOAD, 1'b0}, EXP_MODEL, '{1'b0, 1'b0}},
      '{ROW_BEAT, REG_ROWS, 7'd0,  '{OP_LOAD, 1'b1}, EXP_MODEL, '{1'b0, 1'b0}},
      '{ROW_BEAT, REG_ROWS, 7'd0,  '{OP_EMIT, 1'b0}, EXP_MODEL, '{1'b0, 1'b0}},
      '{ROW_BEAT, REG_ROWS, 7'd0,  '{OP_EMIT, 1'b1}, EXP_MODEL, '{1'b0, 1'b0}},
      '{ROW_BEAT, REG_ROWS, 7'd0,  '{OP_EMIT, 1'b0}, EXP_MODEL, '{1'b0, 1'b0}},
      '{ROW_REG,  REG_MODE, DimW'(ModeOdd), '{OP_LOAD, 1'b0}, EXP_NONE, '{1'b0, 1'b0}},
      '{ROW_BEAT, REG_ROWS, 7'd0,  '{OP_EMIT, 1'b1}, EXP_MODEL, '{1'b0, 1'b0}},
      '{ROW_BEAT, REG_ROWS, 7'd0,  '{OP_EMIT, 1'b0}, EXP_MODEL, '{1'b0, 1'b0}},
      '{ROW_BEAT, REG_ROWS, 7'd0,  '{OP_EMIT, 1'b1}, EXP_MODEL, '{1'b0, 1'b0}},
      '{ROW_REG,  REG_MODE, DimW'(MODE_RIGHT), '{OP_LOAD, 1'b0}, EXP_NONE, '{1'b0, 1'b0}},
      '{ROW_BEAT, REG_ROWS, 7'd0,  '{OP_EMIT, 1'b0}, EXP_MODEL, '{1'b0, 1'b0}},
      '{ROW_BEAT, REG_ROWS, 7'd0,  '{OP_EMIT, 1'b1}, EXP_MODEL, '{1'b0, 1'b0}},
      '{ROW_BEAT, REG_ROWS, 7'd0,  '{OP_EMIT, 1'b0}, EXP_MODEL, '{1'b0, 1'b0}},
      // partial reload: frame no longer complete, emit swallowed
      '{ROW_BEAT, REG_ROWS, 7'd0,  '{OP_LOAD, 1'b0}, EXP_NONE,  '{1'b0, 1'b0}},
      '{ROW_BEAT, REG_ROWS, 7'd0,  '{OP_LOAD, 1'b1}, EXP_NONE,  '{1'b0, 1'b0}},
      '{ROW_BEAT, REG_ROWS, 7'd0,  '{OP_EMIT, 1'b1}, EXP_NONE,  '{1'b0, 1'b0}}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[k]) begin
      if (script[k].kind == ROW_REG) write_reg(script[k].idx, script[k].val);
      else push_beat(script[k].beat, script[k].chk, script[k].want);
    end

    // Random part: mostly whole frames loaded then read out one or two times,
    // with stray beats mixed in; some mode-only phases and pure noise phases.
    nr    = 1;
    nc    = 3;
    fed   = 0;
    phase = 0;
    while (fed < RandBeats) begin
      plan.delete();
      pick = $urandom_range(0, 99);
      if (phase < 2 || pick >= 20) begin
        if (phase == 0) begin
          // saturating row count, tall frame: all row address bits
          rv = 7'h7F;
          cv = 7'd1;
        end else if (phase == 1) begin
          // widest frame: all column address bits
          rv = 7'd2;
          cv = 7'd64;
        end else if (pick >= 95) begin
          rv = ($urandom_range(0, 1) == 0) ? 7'd64 : DimW'($urandom_range(65, 127));
          cv = DimW'($urandom_range(0, 2));
          if ($urandom_range(0, 1) == 0) begin
            cv = rv;
            rv = DimW'($urandom_range(0, 2));
          end
        end else begin
          rv = ($urandom_range(0, 9) == 0) ? 7'd0 : DimW'($urandom_range(1, 8));
          cv = ($urandom_range(0, 9) == 0) ? 7'd0 : DimW'($urandom_range(1, 8));
        end
        write_reg(REG_ROWS, rv);
        write_reg(REG_COLS, cv);
        // upper data bits of a mode write are don't-care
        write_reg(REG_MODE, DimW'($urandom_range(0, 127)));
        if ($urandom_range(0, 9) == 0) write_reg(RegNone, DimW'($urandom_range(0, 127)));
        nr = dim_of(rv, MaxRows);
        nc = dim_of(cv, MaxCols);
        repeat (nr * nc) begin
          if ($urandom_range(0, 24) == 0) begin
            b.opcode   = 1'($urandom_range(0, 1));
            b.pixel_in = 1'($urandom_range(0, 1));
            plan.push_back(b);
          end
          b.opcode   = OP_LOAD;
          b.pixel_in = 1'($urandom_range(0, 1));
          plan.push_back(b);
        end
        reps = nr * nc * $urandom_range(1, 2) + $urandom_range(0, 2);
        repeat (reps) begin
          b.opcode   = OP_EMIT;
          b.pixel_in = 1'($urandom_range(0, 1));
          plan.push_back(b);
        end
      end else if (pick >= 10) begin
        // new direction on the loaded frame
        write_reg(REG_MODE, DimW'($urandom_range(0, 127)));
        repeat (nr * nc + $urandom_range(0, 3)) begin
          b.opcode   = OP_EMIT;
          b.pixel_in = 1'($urandom_range(0, 1));
          plan.push_back(b);
        end
      end else begin
        repeat ($urandom_range(10, 30)) begin
          b.opcode   = 1'($urandom_range(0, 1));
          b.pixel_in = 1'($urandom_range(0, 1));
          plan.push_back(b);
        end
      end
      foreach (plan[k]) begin
        push_beat(plan[k], EXP_MODEL, '0);
        fed++;
        calm = (fed >= RandBeats - RandBeats / 8);
      end
      phase++;
    end

    settle();
    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("bitmap_rotate_quarter_turn_tb: clean");
    end else begin
      $display("bitmap_rotate_quarter_turn_tb: errors");
    end
    $finish;
  end

endmodule
